[hw/rtl/ros_pkg.sv]
// ----------------------------------------------------------------------------
// ros_pkg
// shared constants and control types for the request order sorter
// ----------------------------------------------------------------------------
package ros_pkg;

  localparam int unsigned MaxRequests = 16;
  localparam int unsigned NumAgents   = 16;
  localparam int unsigned OutLimit    = 16;
  localparam int unsigned SlotW       = $clog2(MaxRequests);
  localparam int unsigned CountW      = $clog2(MaxRequests + 1);
  localparam int unsigned AgentW      = 4;
  localparam int unsigned NeedW       = 40;
  localparam int unsigned KeyW        = 33;

  localparam logic [1:0] ModeOldest   = 2'd0;
  localparam logic [1:0] ModePrio     = 2'd1;
  localparam logic [1:0] ModeNeed     = 2'd2;
  localparam logic [1:0] ModeDeadline = 2'd3;

  localparam logic OpNeed    = 1'b0;
  localparam logic OpRequest = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic             load;      // store incoming word
    logic             sort_init; // seed outer index
    logic             cmp_step;  // one insertion compare/shift step
    logic             emit_load; // read order entry for output
    logic             clear;     // clear need table and count
  } ros_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic             sort_done;
    logic [CountW-1:0] count;
  } ros_status_t;

endpackage

[hw/rtl/request_order_sorter_unit.sv]
// ----------------------------------------------------------------------------
// request_order_sorter_unit
// batches requests and emits them in stable policy order
// ----------------------------------------------------------------------------
// Words load at one per cycle while loading. A request word with batch_end
// starts an insertion sort over the stored requests with a single comparator:
// each step compares a request with the entry before its position and either
// shifts that entry up or places the request. Results then leave one per cycle
// through a registered output unless out_stall_i holds; input is stalled during
// sort and emit. Need terms accumulate per agent with saturation; need table and
// count clear when the sort finishes. order_mode must be written while idle.
module request_order_sorter_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        op_i,
  input  logic [3:0]  agent_i,
  input  logic [31:0] claim_max_i,
  input  logic [31:0] claim_held_i,
  input  logic [15:0] request_tag_i,
  input  logic [7:0]  prio_i,
  input  logic [31:0] submit_time_i,
  input  logic        has_timeout_i,
  input  logic [31:0] timeout_ticks_i,
  input  logic        batch_end_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] out_tag_o,
  output logic [3:0]  out_agent_o,
  output logic [3:0]  out_rank_o,
  output logic        out_last_o
);

  // order mode register
  logic [1:0] mode_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) mode_q <= ros_pkg::ModeOldest;
    else if (cfg_we_i) mode_q <= cfg_wdata_i;
  end

  ros_pkg::ros_cmd_t           cmd;
  ros_pkg::ros_status_t        status;
  logic [ros_pkg::CountW-1:0]  emit_idx;

  // sequencer
  ros_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .batch_end_i (batch_end_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rank_o  (out_rank_o),
    .out_last_o  (out_last_o),
    .cmd_o       (cmd),
    .status_i    (status),
    .emit_idx_o  (emit_idx)
  );

  // storage and comparator
  ros_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .mode_i          (mode_q),
    .op_i            (op_i),
    .agent_i         (agent_i),
    .claim_max_i     (claim_max_i),
    .claim_held_i    (claim_held_i),
    .request_tag_i   (request_tag_i),
    .prio_i          (prio_i),
    .submit_time_i   (submit_time_i),
    .has_timeout_i   (has_timeout_i),
    .timeout_ticks_i (timeout_ticks_i),
    .emit_idx_i      (emit_idx),
    .out_tag_o       (out_tag_o),
    .out_agent_o     (out_agent_o)
  );

endmodule

[hw/rtl/ros_datapath.sv]
// ----------------------------------------------------------------------------
// ros_datapath
// request storage, need table, insertion sort with one comparator
// ----------------------------------------------------------------------------
module ros_datapath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ros_pkg::ros_cmd_t          cmd_i,
  output ros_pkg::ros_status_t       status_o,
  input  logic [1:0]                 mode_i,
  input  logic                       op_i,
  input  logic [3:0]                 agent_i,
  input  logic [31:0]                claim_max_i,
  input  logic [31:0]                claim_held_i,
  input  logic [15:0]                request_tag_i,
  input  logic [7:0]                 prio_i,
  input  logic [31:0]                submit_time_i,
  input  logic                       has_timeout_i,
  input  logic [31:0]                timeout_ticks_i,
  input  logic [ros_pkg::CountW-1:0] emit_idx_i,
  output logic [15:0]                out_tag_o,
  output logic [3:0]                 out_agent_o
);

  localparam int unsigned SW = ros_pkg::SlotW;
  localparam int unsigned CW = ros_pkg::CountW;

  logic [15:0]               tag_q   [ros_pkg::MaxRequests];
  logic [7:0]                prio_q  [ros_pkg::MaxRequests];
  logic                      has_q   [ros_pkg::MaxRequests];
  logic [31:0]               sub_q   [ros_pkg::MaxRequests];
  logic [ros_pkg::KeyW-1:0]  key_q   [ros_pkg::MaxRequests];
  logic [3:0]                agt_q   [ros_pkg::MaxRequests];
  logic [ros_pkg::NeedW-1:0] need_q  [ros_pkg::NumAgents];
  logic [SW-1:0]             order_q [ros_pkg::MaxRequests];

  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] i_q, i_d;   // slot being inserted
  logic [CW-1:0] j_q, j_d;   // insertion position

  // need term accumulate
  logic [31:0]               diff;
  logic [ros_pkg::NeedW:0]   nsum;
  assign diff = (claim_max_i > claim_held_i) ? (claim_max_i - claim_held_i) : 32'd0;
  assign nsum = {1'b0, need_q[agent_i]} + {9'd0, diff};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < ros_pkg::NumAgents; k++) need_q[k] <= '0;
    end else if (cmd_i.clear) begin
      for (int k = 0; k < ros_pkg::NumAgents; k++) need_q[k] <= '0;
    end else if (cmd_i.load && op_i == ros_pkg::OpNeed) begin
      need_q[agent_i] <= nsum[ros_pkg::NeedW] ? {ros_pkg::NeedW{1'b1}}
                                              : nsum[ros_pkg::NeedW-1:0];
    end
  end

  // request store
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && op_i == ros_pkg::OpRequest && count_q < CW'(ros_pkg::MaxRequests)) begin
      tag_q[count_q[SW-1:0]]  <= request_tag_i;
      prio_q[count_q[SW-1:0]] <= prio_i;
      has_q[count_q[SW-1:0]]  <= has_timeout_i;
      sub_q[count_q[SW-1:0]]  <= submit_time_i;
      agt_q[count_q[SW-1:0]]  <= agent_i;
      key_q[count_q[SW-1:0]]  <= has_timeout_i ? ({1'b0, submit_time_i} + {1'b0, timeout_ticks_i})
                                               : {1'b0, submit_time_i};
    end
  end

  // comparator: slot cur goes strictly before slot prev
  logic [SW-1:0] cur, prv;
  logic          goes_first;
  assign cur = i_q[SW-1:0];
  assign prv = order_q[j_q[SW-1:0] - SW'(1)];

  always_comb begin
    logic sub_lt;
    sub_lt = sub_q[cur] < sub_q[prv];
    case (mode_i)
      ros_pkg::ModePrio:
        goes_first = (prio_q[cur] != prio_q[prv]) ? (prio_q[cur] > prio_q[prv]) : sub_lt;
      ros_pkg::ModeNeed:
        goes_first = (need_q[agt_q[cur]] != need_q[agt_q[prv]]) ?
                     (need_q[agt_q[cur]] < need_q[agt_q[prv]]) : sub_lt;
      ros_pkg::ModeDeadline:
        if (has_q[cur] && has_q[prv]) goes_first = key_q[cur] < key_q[prv];
        else if (has_q[cur] != has_q[prv]) goes_first = has_q[cur];
        else goes_first = sub_lt;
      default: goes_first = sub_lt;
    endcase
  end

  logic shift;
  assign shift = (j_q != '0) && goes_first;

  always_comb begin
    count_d = count_q;
    i_d     = i_q;
    j_d     = j_q;
    if (cmd_i.clear) count_d = '0;
    else if (cmd_i.load && op_i == ros_pkg::OpRequest && count_q < CW'(ros_pkg::MaxRequests))
      count_d = count_q + CW'(1);
    if (cmd_i.sort_init) begin
      i_d = '0;
      j_d = '0;
    end else if (cmd_i.cmp_step) begin
      if (shift) j_d = j_q - CW'(1);
      else begin
        i_d = i_q + CW'(1);
        j_d = i_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      i_q     <= '0;
      j_q     <= '0;
    end else begin
      count_q <= count_d;
      i_q     <= i_d;
      j_q     <= j_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cmp_step && i_q < count_q) begin
      if (shift) order_q[j_q[SW-1:0]] <= prv;
      else       order_q[j_q[SW-1:0]] <= cur;
    end
  end

  // registered output read
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_load) begin
      out_tag_o   <= tag_q[order_q[emit_idx_i[SW-1:0]]];
      out_agent_o <= agt_q[order_q[emit_idx_i[SW-1:0]]];
    end
  end

  assign status_o.sort_done   = (i_q >= count_q);
  assign status_o.count       = count_q;

endmodule

[hw/rtl/ros_ctrl.sv]
// ----------------------------------------------------------------------------
// ros_ctrl
// sequencer for load, sort and emit phases
// ----------------------------------------------------------------------------
module ros_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       op_i,
  input  logic                       batch_end_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [3:0]                 out_rank_o,
  output logic                       out_last_o,
  output ros_pkg::ros_cmd_t          cmd_o,
  input  ros_pkg::ros_status_t       status_i,
  output logic [ros_pkg::CountW-1:0] emit_idx_o
);

  typedef enum logic [1:0] {
    StLoad,
    StSort,
    StEmit
  } state_e;

  localparam int unsigned CW = ros_pkg::CountW;

  state_e        state_q;
  logic [CW-1:0] idx_q;
  logic [CW-1:0] n_q;
  logic          valid_q;
  logic [3:0]    rank_q;
  logic          last_q;

  logic acc;
  assign acc        = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != StLoad);

  logic [CW-1:0] lim;
  assign lim = (status_i.count < CW'(ros_pkg::OutLimit)) ? status_i.count
                                                         : CW'(ros_pkg::OutLimit);
  logic take;
  assign take = !valid_q || !out_stall_i;

  always_comb begin
    cmd_o           = '0;
    cmd_o.load      = acc;
    cmd_o.sort_init = acc && op_i == ros_pkg::OpRequest && batch_end_i;
    cmd_o.cmp_step  = (state_q == StSort) && !status_i.sort_done;
    cmd_o.emit_load = (state_q == StEmit) && take && idx_q < n_q;
    cmd_o.clear     = (state_q == StSort) && status_i.sort_done;
  end

  assign emit_idx_o  = idx_q;
  assign out_valid_o = valid_q;
  assign out_rank_o  = rank_q;
  assign out_last_o  = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
      idx_q   <= '0;
      n_q     <= '0;
      valid_q <= 1'b0;
      rank_q  <= '0;
      last_q  <= 1'b0;
    end else begin
      if (valid_q && !out_stall_i && !cmd_o.emit_load) valid_q <= 1'b0;
      unique case (state_q)
        StLoad: begin
          if (cmd_o.sort_init) state_q <= StSort;
        end
        StSort: begin
          if (status_i.sort_done) begin
            n_q     <= lim;
            idx_q   <= '0;
            state_q <= (lim == '0) ? StLoad : StEmit;
          end
        end
        StEmit: begin
          if (cmd_o.emit_load) begin
            valid_q <= 1'b1;
            rank_q  <= idx_q[3:0];
            last_q  <= (idx_q + CW'(1) == n_q);
            idx_q   <= idx_q + CW'(1);
            if (idx_q + CW'(1) == n_q) state_q <= StLoad;
          end
        end
        default: state_q <= StLoad;
      endcase
    end
  end

endmodule
